[hdl/aes_pkg.sv]
// shared types, constants and byte-level functions of the aes-128 engine
package aes_pkg;

  localparam int NumKeyWords = 44;
  localparam int KeyWordIdxW = 6;
  localparam int NumRounds   = 10;
  localparam int RoundW      = 4;

  localparam logic CFG_KEY_HIGH = 1'b0;
  localparam logic CFG_KEY_LOW  = 1'b1;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef logic [7:0]   byte_t;
  typedef logic [31:0]  word_t;
  typedef logic [127:0] block_t;

  // controller to datapath
  typedef struct packed {
    logic               load;
    logic               do_round;
    logic               last;
    logic               dec;
    logic [RoundW-1:0]  key_round;
  } aes_cmd_t;

  // key schedule control
  typedef struct packed {
    logic start;
  } aes_key_cmd_t;

  typedef struct packed {
    logic busy;
  } aes_key_sts_t;

  function automatic byte_t xtime(input byte_t a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic byte_t gf_mul(input byte_t a, input byte_t b);
    byte_t acc;
    byte_t p;
    acc = 8'h00;
    p = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc = acc ^ p;
      p = xtime(p);
    end
    gf_mul = acc;
  endfunction

  localparam byte_t SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam byte_t INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

endpackage

[hdl/aes_stream_if.sv]
// valid/ready channel interface carrying a parameterized payload
interface aes_stream_if #(
  parameter type payload_t = logic [127:0]
) (
  input logic clk
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (input clk, output valid, input ready, output data);
  modport sink   (input clk, input valid, output ready, input data);
endinterface

[hdl/aes128_block_cipher_core.sv]
// aes-128 single-block engine top level
//
// channels: blk_in (op, block_high, block_low) and blk_out (result_high,
// result_low), valid/ready; a word is accepted when valid and ready are high.
// configuration: cfg_we/cfg_idx/cfg_data, index 0 key_high, 1 key_low; a key
// write restarts the key expansion.
// key expansion writes one round-key word per cycle into a 44-entry memory;
// it is busy after reset and after a key write until all words are written,
// and no input word is taken then.
// each round fetches its four key words from the single read port, one per
// cycle, waits for the registered read, then updates the state; there are
// eleven key rounds (initial addition and ten rounds). a new block is accepted
// only after the result is taken, so one block is in flight at a time.
// the result holds on blk_out until taken; while the receiver stalls no new
// block is accepted. reset clears control and re-expands the all-zero key.
module aes128_block_cipher_core
  import aes_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_idx,
  input  logic [63:0]       cfg_data,
  aes_stream_if.sink        blk_in,
  aes_stream_if.source      blk_out
);

  logic [63:0] key_high;
  logic [63:0] key_low;
  aes_key_cmd_t key_cmd;
  aes_key_sts_t key_sts;
  logic [KeyWordIdxW-1:0] key_addr;
  logic [1:0] key_col;
  word_t key_word;
  block_t round_key;
  aes_cmd_t cmd;
  block_t state_out;
  logic fetching;
  block_t blk_in_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low <= '0;
      key_cmd.start <= 1'b0;
    end else begin
      key_cmd.start <= cfg_we;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_KEY_HIGH: key_high <= cfg_data;
          CFG_KEY_LOW:  key_low <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  aes_key_sched u_key (
    .clk     (clk),
    .rst     (rst),
    .cmd     (key_cmd),
    .key     ({key_high, key_low}),
    .rd_addr (key_addr),
    .rd_data (key_word),
    .sts     (key_sts)
  );

  aes_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (blk_in.valid),
    .in_ready  (blk_in.ready),
    .in_op     (blk_in.data[128]),
    .out_valid (blk_out.valid),
    .out_ready (blk_out.ready),
    .key_sts   (key_sts),
    .key_addr  (key_addr),
    .key_col   (key_col),
    .cmd       (cmd)
  );

  // gather the four words of the current round key
  assign fetching = blk_out.valid == 1'b0;
  always_ff @(posedge clk) begin
    if (fetching) round_key[127 - 32*key_col -: 32] <= key_word;
  end

  aes_datapath u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .in_block  (blk_in_hold),
    .round_key (round_key),
    .state_out (state_out)
  );

  always_ff @(posedge clk) begin
    if (blk_in.valid && blk_in.ready) blk_in_hold <= blk_in.data[127:0];
  end

  assign blk_out.data = state_out;

endmodule

[hdl/aes_key_sched.sv]
// round-key expansion from the 128-bit key, one word per cycle into a memory
module aes_key_sched
  import aes_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  aes_key_cmd_t           cmd,
  input  logic [127:0]           key,
  input  logic [KeyWordIdxW-1:0] rd_addr,
  output word_t                  rd_data,
  output aes_key_sts_t           sts
);

  word_t mem [NumKeyWords];
  word_t win [4];
  logic [KeyWordIdxW-1:0] widx;
  byte_t rcon;
  logic busy;
  word_t t;
  word_t new_word;
  word_t rot;

  always_comb begin
    rot = {win[3][23:0], win[3][31:24]};
    if (widx[1:0] == 2'd0) begin
      t = {SBOX[rot[31:24]], SBOX[rot[23:16]], SBOX[rot[15:8]], SBOX[rot[7:0]]} ^
          {rcon, 24'h0};
    end else begin
      t = win[3];
    end
    new_word = win[0] ^ t;
  end

  // restart on a key write; reset starts with the all-zero key
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      widx <= '0;
      rcon <= 8'h01;
      for (int i = 0; i < 4; i++) win[i] <= '0;
    end else if (cmd.start) begin
      busy <= 1'b1;
      widx <= '0;
      rcon <= 8'h01;
      win[0] <= key[127:96];
      win[1] <= key[95:64];
      win[2] <= key[63:32];
      win[3] <= key[31:0];
    end else if (busy) begin
      if (widx < KeyWordIdxW'(4)) begin
        mem[widx] <= win[widx[1:0]];
        widx <= widx + 1'b1;
      end else begin
        mem[widx] <= new_word;
        win[0] <= win[1];
        win[1] <= win[2];
        win[2] <= win[3];
        win[3] <= new_word;
        if (widx[1:0] == 2'd0) rcon <= xtime(rcon);
        if (widx == KeyWordIdxW'(NumKeyWords - 1)) busy <= 1'b0;
        else widx <= widx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  // a pending restart already counts as busy
  assign sts.busy = busy | cmd.start;

endmodule

[hdl/aes_datapath.sv]
// state register and round logic for cipher and inverse cipher, reused every round
module aes_datapath
  import aes_pkg::*;
(
  input  logic     clk,
  input  aes_cmd_t cmd,
  input  block_t   in_block,
  input  block_t   round_key,
  output block_t   state_out
);

  block_t st;
  byte_t  s   [16];
  byte_t  sb  [16];
  byte_t  sr  [16];
  byte_t  mc  [16];
  byte_t  fwd [16];
  byte_t  bwd [16];
  byte_t  isr [16];
  byte_t  isb [16];
  byte_t  ak  [16];
  byte_t  k   [16];
  block_t next;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = st[127 - 8*i -: 8];
      k[i] = round_key[127 - 8*i -: 8];
    end
    // encrypt: sub, shift, mix (skipped in the last round), add key
    for (int i = 0; i < 16; i++) sb[i] = SBOX[s[i]];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        sr[c*4 + r] = sb[((c + r) & 3)*4 + r];
    for (int c = 0; c < 4; c++) begin
      mc[c*4+0] = xtime(sr[c*4]) ^ xtime(sr[c*4+1]) ^ sr[c*4+1] ^ sr[c*4+2] ^ sr[c*4+3];
      mc[c*4+1] = sr[c*4] ^ xtime(sr[c*4+1]) ^ xtime(sr[c*4+2]) ^ sr[c*4+2] ^ sr[c*4+3];
      mc[c*4+2] = sr[c*4] ^ sr[c*4+1] ^ xtime(sr[c*4+2]) ^ xtime(sr[c*4+3]) ^ sr[c*4+3];
      mc[c*4+3] = xtime(sr[c*4]) ^ sr[c*4] ^ sr[c*4+1] ^ sr[c*4+2] ^ xtime(sr[c*4+3]);
    end
    for (int i = 0; i < 16; i++) fwd[i] = (cmd.last ? sr[i] : mc[i]) ^ k[i];
    // decrypt: inv shift, inv sub, add key, inv mix (skipped in the last round)
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        isr[((c + r) & 3)*4 + r] = s[c*4 + r];
    for (int i = 0; i < 16; i++) begin
      isb[i] = INV_SBOX[isr[i]];
      ak[i]  = isb[i] ^ k[i];
    end
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        bwd[c*4 + r] = cmd.last ? ak[c*4 + r] :
          gf_mul(8'h0e, ak[c*4 + r]) ^
          gf_mul(8'h0b, ak[c*4 + ((r + 1) & 3)]) ^
          gf_mul(8'h0d, ak[c*4 + ((r + 2) & 3)]) ^
          gf_mul(8'h09, ak[c*4 + ((r + 3) & 3)]);
    for (int i = 0; i < 16; i++)
      next[127 - 8*i -: 8] = cmd.dec ? bwd[i] : fwd[i];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) st <= in_block ^ round_key;
    else if (cmd.do_round) st <= next;
  end

  assign state_out = st;

endmodule

[hdl/aes_ctrl.sv]
// round sequencer: key word fetch, round count and handshakes
module aes_ctrl
  import aes_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_op,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  aes_key_sts_t           key_sts,
  output logic [KeyWordIdxW-1:0] key_addr,
  output logic [1:0]             key_col,
  output aes_cmd_t               cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FETCH = 3'd1;
  localparam logic [2:0] ST_DONE  = 3'd2;

  logic [2:0]        state, state_next;
  logic              dec;
  logic [RoundW-1:0] rnd;   // key round now being fetched
  logic [RoundW-1:0] steps; // rounds applied
  logic [2:0]        wcnt;  // 0..5: four word reads, read latency, then the round
  logic              fetch_done;
  logic              in_op_seen; // set once initial key addition is done

  assign in_ready  = (state == ST_IDLE) && !key_sts.busy;
  assign out_valid = (state == ST_DONE);
  // the key memory read is registered, so key_col trails the read address by one word
  assign key_addr  = KeyWordIdxW'({rnd, 2'b00}) + KeyWordIdxW'(wcnt[1:0]);
  assign key_col   = wcnt[1:0] - 2'd1;
  assign fetch_done = (wcnt == 3'd5);

  always_comb begin
    cmd.dec       = dec;
    cmd.key_round = rnd;
    cmd.load      = (state == ST_FETCH) && fetch_done && (steps == '0) && !in_op_seen;
    cmd.do_round  = (state == ST_FETCH) && fetch_done && in_op_seen;
    cmd.last      = (steps == RoundW'(NumRounds - 1));
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid && in_ready) state_next = ST_FETCH;
      ST_FETCH: if (fetch_done && in_op_seen && cmd.last) state_next = ST_DONE;
      ST_DONE:  if (out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      dec <= OP_ENCRYPT;
      rnd <= '0;
      steps <= '0;
      wcnt <= '0;
      in_op_seen <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            dec <= in_op;
            rnd <= (in_op == OP_DECRYPT) ? RoundW'(NumRounds) : '0;
            steps <= '0;
            wcnt <= '0;
            in_op_seen <= 1'b0;
          end
        end
        ST_FETCH: begin
          if (fetch_done) begin
            wcnt <= '0;
            if (in_op_seen) steps <= steps + 1'b1;
            in_op_seen <= 1'b1;
            rnd <= dec ? rnd - 1'b1 : rnd + 1'b1;
          end else begin
            wcnt <= wcnt + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
